FILE: design/s256bs_pkg.sv
`default_nettype none
package s256bs_pkg;

   localparam int unsigned HASH_WORDS = 8;
   localparam int unsigned ROUNDS     = 64;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LEN_START  = 6'd56;   // first byte of the length field
   localparam logic [5:0] BLOCK_END  = 6'd63;   // last byte of a 64-byte block

   localparam logic [31:0] INIT_H [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // byte intake and message schedule control
   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       word_done;
      logic       expand;
   } sched_ctl_type;

   // round unit and chaining word control
   typedef struct packed {
      logic       load;
      logic       round;
      logic [5:0] round_idx;
      logic       fold;
      logic       unload;
      logic       restart;
   } round_ctl_type;

endpackage
`default_nettype wire

FILE: design/s256bs_if.sv
`default_nettype none
interface s256bs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last;

   modport source (output valid, data_byte, byte_present, last, input ready);
   modport sink   (input valid, data_byte, byte_present, last, output ready);
endinterface

interface s256bs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: design/s256bs_sched.sv
`default_nettype none
module s256bs_sched (
   input  wire logic                    clock,
   input  wire s256bs_pkg::sched_ctl_type ctl,
   output logic [31:0]                  w_cur
);

   logic [23:0] acc_ff;
   logic [31:0] win_ff [16];
   logic [31:0] w_new;
   logic [31:0] shift_word;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // window: entry 0 is the oldest word, W(t) during round t
   assign w_new = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   assign shift_word = ctl.expand ? w_new : {acc_ff, ctl.data};
   assign w_cur = win_ff[0];

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         acc_ff <= {acc_ff[15:0], ctl.data};
      end
      if (ctl.expand || ctl.word_done) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= shift_word;
      end
   end

endmodule
`default_nettype wire

FILE: design/s256bs_round.sv
`default_nettype none
module s256bs_round (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire s256bs_pkg::round_ctl_type ctl,
   input  wire logic [31:0]             w_cur,
   output logic [31:0]                  head_word
);

   logic [31:0] chain_ff [s256bs_pkg::HASH_WORDS];
   logic [31:0] v_ff [s256bs_pkg::HASH_WORDS];
   logic [31:0] t1;
   logic [31:0] t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + s256bs_pkg::ROUND_K[ctl.round_idx] + w_cur;
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign head_word = chain_ff[0];

   // working variables a..h
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= chain_ff[i];
         end
      end else if (ctl.round) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   // chaining words; rotate toward word 0 while the digest drains
   always_ff @(posedge clock) begin
      if (reset || ctl.restart) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= s256bs_pkg::INIT_H[i];
         end
      end else if (ctl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
      end else if (ctl.unload) begin
         for (int i = 0; i < 7; i++) begin
            chain_ff[i] <= chain_ff[i + 1];
         end
         chain_ff[7] <= chain_ff[0];
      end
   end

endmodule
`default_nettype wire

FILE: design/sha256_byte_stream_core.sv
// Message bytes: one request per cycle while the core is idle, not compressing, padding or sending a digest.
// Each 64th byte starts a compression: the rounds, then a fold into the chaining words.
// A request with last: padding over one or two blocks, one or two compressions,
// then eight digest words, one per accepted response cycle.
// Synchronous active-high reset restores the initial hash, empty fill and
// zero length; the schedule window and working variables hold no reset value.
`default_nettype none
module sha256_byte_stream_core (
   input  wire logic    clock,
   input  wire logic    reset,
   s256bs_req_if.sink   req_ch,
   s256bs_rsp_if.source rsp_ch
);

   // Control state
   s256bs_pkg::state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;        // byte position in the current block
   logic [63:0] bits_ff, bits_in;        // message length in bits, mod 2^64
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        last_pend_ff, last_pend_in;     // padding owed after this block
   logic        pad_first_ff, pad_first_in;     // next pad byte is the marker
   logic        need_extra_ff, need_extra_in;   // length goes to a second block
   logic        pad_final_ff, pad_final_in;     // block in flight ends the message

   logic        req_acc;
   logic        rsp_acc;
   logic        push;
   logic [7:0]  push_byte;
   logic        len_zone;
   logic        block_full;
   logic [31:0] w_cur;
   logic [31:0] head_word;

   s256bs_pkg::sched_ctl_type sched_ctl;
   s256bs_pkg::round_ctl_type round_ctl;

   assign req_ch.ready = (state_ff == s256bs_pkg::ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   // Result channel straight from registers: word 0 of the rotating chain.
   assign rsp_ch.valid       = (state_ff == s256bs_pkg::ST_OUT);
   assign rsp_ch.digest_word = head_word;
   assign rsp_ch.word_index  = out_idx_ff;
   assign rsp_ch.last_word   = (out_idx_ff == 3'(s256bs_pkg::HASH_WORDS - 1));
   assign rsp_acc            = rsp_ch.valid && rsp_ch.ready;

   // Length bytes fill positions 56..63 of the final block, big-endian.
   assign len_zone = !pad_first_ff && !need_extra_ff && (fill_ff >= s256bs_pkg::LEN_START);

   always_comb begin
      push      = 1'b0;
      push_byte = req_ch.data_byte;
      case (state_ff)
         s256bs_pkg::ST_IDLE: begin
            push = req_acc && req_ch.byte_present;
         end
         s256bs_pkg::ST_PAD: begin
            push = 1'b1;
            if (pad_first_ff) begin
               push_byte = s256bs_pkg::PAD_MARKER;
            end else if (len_zone) begin
               push_byte = bits_ff[63:56];
            end else begin
               push_byte = 8'h00;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign block_full = push && (fill_ff == s256bs_pkg::BLOCK_END);

   always_comb begin
      state_in      = state_ff;
      fill_in       = push ? fill_ff + 6'd1 : fill_ff;
      bits_in       = bits_ff;
      round_in      = round_ff;
      out_idx_in    = out_idx_ff;
      last_pend_in  = last_pend_ff;
      pad_first_in  = pad_first_ff;
      need_extra_in = need_extra_ff;
      pad_final_in  = pad_final_ff;

      case (state_ff)
         s256bs_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.byte_present) begin
                  bits_in = bits_ff + 64'd8;
               end
               if (req_ch.last) begin
                  last_pend_in = 1'b1;
                  pad_first_in = 1'b1;
               end
               if (block_full) begin
                  state_in = s256bs_pkg::ST_ROUND;
                  round_in = '0;
               end else if (req_ch.last) begin
                  state_in = s256bs_pkg::ST_PAD;
               end
            end
         end
         s256bs_pkg::ST_PAD: begin
            if (pad_first_ff) begin
               pad_first_in  = 1'b0;
               // marker in the length field: one more block of zeros first
               need_extra_in = (fill_ff >= s256bs_pkg::LEN_START);
            end else if (len_zone) begin
               bits_in = bits_ff << 8;
            end
            if (block_full) begin
               pad_final_in  = pad_first_ff ? (fill_ff < s256bs_pkg::LEN_START)
                                            : !need_extra_ff;
               need_extra_in = 1'b0;
               state_in      = s256bs_pkg::ST_ROUND;
               round_in      = '0;
            end
         end
         s256bs_pkg::ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(s256bs_pkg::ROUNDS - 1)) begin
               state_in = s256bs_pkg::ST_FOLD;
            end
         end
         s256bs_pkg::ST_FOLD: begin
            if (pad_final_ff) begin
               state_in   = s256bs_pkg::ST_OUT;
               out_idx_in = '0;
            end else if (last_pend_ff) begin
               state_in = s256bs_pkg::ST_PAD;
            end else begin
               state_in = s256bs_pkg::ST_IDLE;
            end
         end
         s256bs_pkg::ST_OUT: begin
            if (rsp_acc) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (rsp_ch.last_word) begin
                  // digest delivered: ready for the next message
                  state_in     = s256bs_pkg::ST_IDLE;
                  bits_in      = '0;
                  last_pend_in = 1'b0;
                  pad_final_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = s256bs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= s256bs_pkg::ST_IDLE;
         fill_ff       <= '0;
         bits_ff       <= '0;
         round_ff      <= '0;
         out_idx_ff    <= '0;
         last_pend_ff  <= 1'b0;
         pad_first_ff  <= 1'b0;
         need_extra_ff <= 1'b0;
         pad_final_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bits_ff       <= bits_in;
         round_ff      <= round_in;
         out_idx_ff    <= out_idx_in;
         last_pend_ff  <= last_pend_in;
         pad_first_ff  <= pad_first_in;
         need_extra_ff <= need_extra_in;
         pad_final_ff  <= pad_final_in;
      end
   end

   // Bytes pack big-endian into words; each fourth byte shifts a word into
   // the schedule window. During rounds the window expands W in place.
   assign sched_ctl.push      = push;
   assign sched_ctl.data      = push_byte;
   assign sched_ctl.word_done = push && (fill_ff[1:0] == 2'b11);
   assign sched_ctl.expand    = (state_ff == s256bs_pkg::ST_ROUND);

   // Working variables load from the chain on the edge that completes a block.
   assign round_ctl.load      = block_full;
   assign round_ctl.round     = (state_ff == s256bs_pkg::ST_ROUND);
   assign round_ctl.round_idx = round_ff;
   assign round_ctl.fold      = (state_ff == s256bs_pkg::ST_FOLD);
   assign round_ctl.unload    = rsp_acc;
   assign round_ctl.restart   = rsp_acc && rsp_ch.last_word;

   s256bs_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_cur (w_cur)
   );

   s256bs_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (round_ctl),
      .w_cur     (w_cur),
      .head_word (head_word)
   );

endmodule
`default_nettype wire

FILE: design/s256bs_chk.sv
`default_nettype none
module s256bs_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_last,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_word_index,
   input wire logic       rsp_last_word
);

   logic req_acc;
   logic rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // no new request while a digest drains
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken while digest pending");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_last_word |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of order");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last word flag mismatch");

   a_ready_after_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_last_word |=> req_ready)
      else $error("not ready after digest");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_last |=> !req_ready)
      else $error("ready right after end of message");

endmodule

bind sha256_byte_stream_core s256bs_chk u_s256bs_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_last       (req_ch.last),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_word_index (rsp_ch.word_index),
   .rsp_last_word  (rsp_ch.last_word)
);
`default_nettype wire
